// File: rtl/core/reas_pkg.sv
// Shared constants, types and register codes of the row edge activity scanner.
`default_nettype none
package reas_pkg;
	localparam int MaxWidth    = 1024;
	localparam int HeightLimit = 1024;
	localparam int ColW        = $clog2(MaxWidth);
	localparam int RowW        = 10;
	localparam int CfgW        = 11;
	localparam int GrayW       = 8;
	localparam int ThrW        = 8;
	localparam int CntW        = 10;
	localparam int ColOutW     = 11;
	localparam int IdxW        = 2;

	localparam logic [IdxW-1:0] RegLineWidth     = 2'd0;
	localparam logic [IdxW-1:0] RegFrameHeight   = 2'd1;
	localparam logic [IdxW-1:0] RegEdgeThreshold = 2'd2;

	localparam logic [CfgW-1:0] WidthReset     = 11'd1024;
	localparam logic [CfgW-1:0] HeightReset    = 11'd1024;
	localparam logic [ThrW-1:0] ThresholdReset = 8'd18;
	localparam int              MinSide        = 3;

	// Band limits: floor(w/45) and floor(3w/5) as multiplications by scaled reciprocals.
	localparam int LoFloor    = 10;
	localparam int RecipShift = 16;
	localparam int LoRecip    = 1457;
	localparam int HiRecip    = 39324;

	typedef struct packed {
		logic [GrayW-1:0] upper;
		logic [GrayW-1:0] middle;
		logic             covered;
	} reas_line_t;

	typedef struct packed {
		logic [ColW:0]     width;
		logic [CfgW-1:0]   height;
		logic [ThrW-1:0]   threshold;
		logic [CntW-1:0]   band_lo;
		logic [CntW-1:0]   band_hi;
		logic              restart;
	} reas_geom_t;
endpackage
`default_nettype wire

// File: rtl/core/reas_pix_if.sv
// Pixel channel: valid, ready and one grayscale pixel with its coverage flag.
`default_nettype none
interface reas_pix_if;
	logic                        valid;
	logic                        ready;
	logic [reas_pkg::GrayW-1:0]  gray_level;
	logic                        covered;
	modport source(output valid, gray_level, covered, input ready);
	modport sink(input valid, gray_level, covered, output ready);
endinterface
`default_nettype wire

// File: rtl/core/reas_row_if.sv
// Row summary channel: valid, ready and the edge profile of one inner row.
`default_nettype none
interface reas_row_if;
	logic                                valid;
	logic                                ready;
	logic [reas_pkg::RowW-1:0]           row_index;
	logic [reas_pkg::CntW-1:0]           edge_total;
	logic [reas_pkg::ColOutW-1:0]        first_column;
	logic signed [reas_pkg::ColOutW-1:0] last_column;
	logic                                row_active;
	modport source(output valid, row_index, edge_total, first_column, last_column, row_active,
		input ready);
	modport sink(input valid, row_index, edge_total, first_column, last_column, row_active,
		output ready);
endinterface
`default_nettype wire

// File: rtl/core/row_edge_activity_scan_top.sv
// Top level of the row edge activity scanner: counters, gradient test and row summaries.
// The block takes one pixel per clock in raster order while the input is not stalled and, after
// the last pixel of each row from row 2 on, registers the edge summary of the row above. The two
// previous rows live in one 1024-entry line store with two registered read ports; the entries
// for the coming column and its right neighbor are fetched ahead, so the test, the write-back
// and the row counters all complete in the cycle the pixel transfers. A summary waits in an
// output register; the input stalls only when a pixel would close a row while that register
// is still full and not being taken. Writing the width or height restarts the frame at once;
// the line store needs no clearing pass because every entry read is written one row earlier.
`default_nettype none
module row_edge_activity_scan_top (
	input  wire                        clk,
	input  wire                        arst_n,
	reas_pix_if.sink                   pixel,
	reas_row_if.source                 summary,
	input  wire                        cfg_wr_en,
	input  wire [reas_pkg::IdxW-1:0]   cfg_index,
	input  wire [reas_pkg::CfgW-1:0]   cfg_data
);
	reas_pkg::reas_geom_t         geom;
	reas_pkg::reas_line_t         rd_cur;
	reas_pkg::reas_line_t         rd_next;
	reas_pkg::reas_line_t         wr_entry;

	logic [reas_pkg::ColW-1:0]    col_q;
	logic [reas_pkg::RowW-1:0]    row_q;
	logic [reas_pkg::CntW-1:0]    cnt_q;
	logic [reas_pkg::ColW-1:0]    first_q;
	logic [reas_pkg::ColW-1:0]    last_q;
	logic [reas_pkg::GrayW-1:0]   prev_mid_q;

	logic                         res_valid_q;
	logic [reas_pkg::RowW-1:0]    res_row_q;
	logic [reas_pkg::CntW-1:0]    res_cnt_q;
	logic [reas_pkg::ColOutW-1:0] res_first_q;
	logic [reas_pkg::ColOutW-1:0] res_last_q;
	logic                         res_active_q;

	logic                         accept;
	logic [reas_pkg::ColW-1:0]    col_last;
	logic                         last_col;
	logic                         has_result;
	logic [reas_pkg::ColW-1:0]    col_next;
	logic [reas_pkg::RowW:0]      row_inc;
	logic                         inner;
	logic [reas_pkg::GrayW-1:0]   hz;
	logic [reas_pkg::GrayW-1:0]   vt;
	logic [reas_pkg::GrayW-1:0]   grad;
	logic                         is_edge;

	function automatic logic [reas_pkg::GrayW-1:0] absdiff(
		input logic [reas_pkg::GrayW-1:0] a,
		input logic [reas_pkg::GrayW-1:0] b
	);
		return (a > b) ? a - b : b - a;
	endfunction

	reas_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom)
	);

	assign col_last   = reas_pkg::ColW'(geom.width - 1'b1);
	assign last_col   = (col_q == col_last);
	assign has_result = last_col && (row_q >= reas_pkg::RowW'(2));
	assign pixel.ready = !(res_valid_q && !summary.ready && has_result);
	assign accept     = pixel.valid && pixel.ready;

	always_comb begin
		if (geom.restart) begin
			col_next = '0;
		end else if (accept) begin
			col_next = last_col ? '0 : col_q + 1'b1;
		end else begin
			col_next = col_q;
		end
	end

	assign wr_entry.upper   = rd_cur.middle;
	assign wr_entry.middle  = pixel.gray_level;
	assign wr_entry.covered = pixel.covered;

	reas_line_ram u_line_ram (
		.clk       (clk),
		.wr_en     (accept),
		.wr_addr   (col_q),
		.wr_data   (wr_entry),
		.rd_addr_a (col_next),
		.rd_addr_b (col_next + 1'b1),
		.rd_data_a (rd_cur),
		.rd_data_b (rd_next)
	);

	assign inner   = (row_q >= reas_pkg::RowW'(2)) && (col_q != '0) && !last_col &&
		!rd_cur.covered;
	assign hz      = absdiff(rd_next.middle, prev_mid_q);
	assign vt      = absdiff(pixel.gray_level, rd_cur.upper);
	assign grad    = (hz > vt) ? hz : vt;
	assign is_edge = inner && (grad >= geom.threshold);
	assign row_inc = {1'b0, row_q} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			cnt_q      <= '0;
			prev_mid_q <= '0;
		end else if (geom.restart) begin
			col_q      <= '0;
			row_q      <= '0;
			cnt_q      <= '0;
			prev_mid_q <= '0;
		end else if (accept) begin
			col_q <= col_next;
			if (last_col) begin
				cnt_q      <= '0;
				prev_mid_q <= '0;
				row_q      <= (reas_pkg::CfgW'(row_inc) >= geom.height) ?
					'0 : row_inc[reas_pkg::RowW-1:0];
			end else begin
				prev_mid_q <= rd_cur.middle;
				if (is_edge) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// The column bounds only mean something while the count is nonzero.
	always_ff @(posedge clk) begin
		if (accept && is_edge) begin
			if (cnt_q == '0 || col_q < first_q) begin
				first_q <= col_q;
			end
			last_q <= col_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept && has_result) begin
			res_valid_q <= 1'b1;
		end else if (summary.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && has_result) begin
			res_row_q    <= row_q - 1'b1;
			res_cnt_q    <= cnt_q;
			res_first_q  <= (cnt_q == '0) ? reas_pkg::ColOutW'(geom.width) :
				reas_pkg::ColOutW'(first_q);
			res_last_q   <= (cnt_q == '0) ? '1 : reas_pkg::ColOutW'(last_q);
			res_active_q <= (cnt_q >= geom.band_lo) && (cnt_q <= geom.band_hi);
		end
	end

	assign summary.valid        = res_valid_q;
	assign summary.row_index    = res_row_q;
	assign summary.edge_total   = res_cnt_q;
	assign summary.first_column = res_first_q;
	assign summary.last_column  = $signed(res_last_q);
	assign summary.row_active   = res_active_q;

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, col_q} < geom.width)
		else $error("Column counter is beyond the row width.");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= reas_pkg::CntW'(col_q))
		else $error("Edge count exceeds the columns seen in this row.");

	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !last_col && !geom.restart |=> col_q == $past(col_q) + 1'b1)
		else $error("Column counter did not advance after a transfer.");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		accept && has_result |=> res_valid_q)
		else $error("Row summary was not loaded at the end of a row.");

	a_bounds_order: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 |-> last_q >= first_q)
		else $error("Last edge column lies left of the first.");
endmodule
`default_nettype wire

// File: rtl/core/reas_line_ram.sv
// Line store: one write port and two registered read ports over all columns.
`default_nettype none
module reas_line_ram (
	input  wire                          clk,
	input  wire                          wr_en,
	input  wire  [reas_pkg::ColW-1:0]    wr_addr,
	input  wire  reas_pkg::reas_line_t   wr_data,
	input  wire  [reas_pkg::ColW-1:0]    rd_addr_a,
	input  wire  [reas_pkg::ColW-1:0]    rd_addr_b,
	output reas_pkg::reas_line_t         rd_data_a,
	output reas_pkg::reas_line_t         rd_data_b
);
	reas_pkg::reas_line_t mem [reas_pkg::MaxWidth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end
endmodule
`default_nettype wire

// File: rtl/core/reas_cfg.sv
// Configuration registers, saturated frame geometry and activity band limits.
`default_nettype none
module reas_cfg (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_wr_en,
	input  wire  [reas_pkg::IdxW-1:0]    cfg_index,
	input  wire  [reas_pkg::CfgW-1:0]    cfg_data,
	output reas_pkg::reas_geom_t         geom
);
	logic [reas_pkg::CfgW-1:0]   width_q;
	logic [reas_pkg::CfgW-1:0]   height_q;
	logic [reas_pkg::ThrW-1:0]   threshold_q;
	logic [reas_pkg::CntW-1:0]   band_lo_q;
	logic [reas_pkg::CntW-1:0]   band_hi_q;
	logic [reas_pkg::ColW:0]     eff_width;
	logic [reas_pkg::CfgW-1:0]   eff_height;
	logic [reas_pkg::ColW+16:0]  lo_prod;
	logic [reas_pkg::ColW+18:0]  hi_prod;
	logic [reas_pkg::CntW-1:0]   lo_div;
	logic [reas_pkg::CntW-1:0]   hi_div;
	logic [reas_pkg::CntW-1:0]   lo_val;
	logic [reas_pkg::CntW-1:0]   hi_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= reas_pkg::WidthReset;
			height_q    <= reas_pkg::HeightReset;
			threshold_q <= reas_pkg::ThresholdReset;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				reas_pkg::RegLineWidth:     width_q     <= cfg_data;
				reas_pkg::RegFrameHeight:   height_q    <= cfg_data;
				reas_pkg::RegEdgeThreshold: threshold_q <= cfg_data[reas_pkg::ThrW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q < reas_pkg::CfgW'(reas_pkg::MinSide)) begin
			eff_width = (reas_pkg::ColW+1)'(reas_pkg::MinSide);
		end else if (width_q > reas_pkg::CfgW'(reas_pkg::MaxWidth)) begin
			eff_width = (reas_pkg::ColW+1)'(reas_pkg::MaxWidth);
		end else begin
			eff_width = width_q[reas_pkg::ColW:0];
		end
		if (height_q < reas_pkg::CfgW'(reas_pkg::MinSide)) begin
			eff_height = reas_pkg::CfgW'(reas_pkg::MinSide);
		end else if (height_q > reas_pkg::CfgW'(reas_pkg::HeightLimit)) begin
			eff_height = reas_pkg::CfgW'(reas_pkg::HeightLimit);
		end else begin
			eff_height = height_q;
		end
	end

	assign lo_prod = (reas_pkg::ColW+17)'(eff_width) * (reas_pkg::ColW+17)'(reas_pkg::LoRecip);
	assign hi_prod = (reas_pkg::ColW+19)'(eff_width) * (reas_pkg::ColW+19)'(reas_pkg::HiRecip);
	assign lo_div  = lo_prod[reas_pkg::RecipShift +: reas_pkg::CntW];
	assign hi_div  = hi_prod[reas_pkg::RecipShift +: reas_pkg::CntW];
	assign lo_val  = (lo_div < reas_pkg::CntW'(reas_pkg::LoFloor)) ?
		reas_pkg::CntW'(reas_pkg::LoFloor) : lo_div;
	assign hi_val  = (hi_div < lo_val + 1'b1) ? lo_val + 1'b1 : hi_div;

	// The limits are registered and follow the width well before any row closes.
	always_ff @(posedge clk) begin
		band_lo_q <= lo_val;
		band_hi_q <= hi_val;
	end

	assign geom.width     = eff_width;
	assign geom.height    = eff_height;
	assign geom.threshold = threshold_q;
	assign geom.band_lo   = band_lo_q;
	assign geom.band_hi   = band_hi_q;
	assign geom.restart   = cfg_wr_en &&
		(cfg_index == reas_pkg::RegLineWidth || cfg_index == reas_pkg::RegFrameHeight);
endmodule
`default_nettype wire
